FILE: design/ebce_pkg.sv
// ----------------------------------------------------------------------------
// ebce_pkg - shared types and constants for the CPU execute step
// Opcode codes, register indexes, ALU operation codes, flag and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebce_pkg;

  // Result status of one instruction
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HALT  = 2'd1,
    ST_UNSUP = 2'd2
  } status_t;

  // ALU operation, bits 5..3 of the ALU opcode group
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBC = 3'd3,
    ALU_AND = 3'd4,
    ALU_XOR = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CP  = 3'd7
  } alu_op_t;

  // Flags as held in state: Z N H C
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // ALU result bundle
  typedef struct packed {
    logic [7:0] acc;
    flags_t     flags;
  } alu_res_t;

  // Operand selector codes (3-bit register field)
  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam int unsigned NUM_GPR = 6;

  // Opcodes with special handling
  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_JR     = 8'h18;
  localparam logic [7:0] OP_JR_NZ  = 8'h20;
  localparam logic [7:0] OP_JR_Z   = 8'h28;
  localparam logic [7:0] OP_JR_NC  = 8'h30;
  localparam logic [7:0] OP_JR_C   = 8'h38;
  localparam logic [7:0] OP_HALT   = 8'h76;
  localparam logic [7:0] OP_JP     = 8'hC3;
  localparam logic [7:0] OP_CP_D8  = 8'hFE;

endpackage

`default_nettype wire

FILE: design/ebce_alu.sv
// ----------------------------------------------------------------------------
// ebce_alu - 8-bit accumulator ALU
// ADD/ADC/SUB/SBC/AND/XOR/OR/CP with Z, N, H, C flag generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebce_alu (
  input  wire logic [7:0]       acc,
  input  wire logic [7:0]       operand,
  input  wire logic             carry_in,
  input  wire ebce_pkg::alu_op_t op,
  output ebce_pkg::alu_res_t    res
);

  logic       cy;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] diff9;
  logic [4:0] diff5;
  logic [7:0] val;

  // carry only used by ADC and SBC
  assign cy = ((op == ebce_pkg::ALU_ADC) || (op == ebce_pkg::ALU_SBC)) ? carry_in : 1'b0;

  assign sum9  = {1'b0, acc} + {1'b0, operand} + {8'd0, cy};
  assign sum5  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cy};
  assign diff9 = {1'b0, acc} - {1'b0, operand} - {8'd0, cy};
  assign diff5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cy};

  // result and flags per operation
  always_comb begin
    val       = 8'd0;
    res.acc   = acc;
    res.flags = '0;
    case (op)
      ebce_pkg::ALU_ADD, ebce_pkg::ALU_ADC: begin
        val         = sum9[7:0];
        res.acc     = val;
        res.flags.h = sum5[4];
        res.flags.c = sum9[8];
      end
      ebce_pkg::ALU_SUB, ebce_pkg::ALU_SBC, ebce_pkg::ALU_CP: begin
        val         = diff9[7:0];
        res.flags.n = 1'b1;
        res.flags.h = diff5[4];
        res.flags.c = diff9[8];
        // compare keeps A
        if (op != ebce_pkg::ALU_CP) begin
          res.acc = val;
        end
      end
      ebce_pkg::ALU_AND: begin
        val         = acc & operand;
        res.acc     = val;
        res.flags.h = 1'b1;
      end
      ebce_pkg::ALU_XOR: begin
        val     = acc ^ operand;
        res.acc = val;
      end
      default: begin
        val     = acc | operand;
        res.acc = val;
      end
    endcase
    res.flags.z = (val == 8'd0);
  end

endmodule

`default_nettype wire

FILE: design/eight_bit_cpu_execute_step.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_step - execute stage of an 8-bit accumulator CPU
// Runs one fetched instruction per transaction and reports A, F, PC, stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one fetched instruction: the
//   opcode, the two following bytes and the byte currently at (HL).
//   Result channel (out_valid/out_ready) returns A, F, the next PC, an
//   optional store request to (HL), and a status code (executed, halt,
//   unsupported opcode).
//   An accepted instruction waits in the input register while decode,
//   register read, ALU and state update run combinationally into the
//   result register, which drives out_valid.
//   Throughput is one instruction per cycle unless the receiver stalls;
//   each instruction sees the register file as left by the previous one,
//   since the state and the result register update on the same edge.
//   If the receiver stalls, the result register holds and the input register
//   fills; in_ready drops only when both are occupied.
//   Synchronous reset clears B..L, A, F and PC to zero and empties both
//   registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_cpu_execute_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_opcode,
  input  wire logic [15:0] in_operand_word,
  input  wire logic [7:0]  in_hl_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_acc_value,
  output logic [7:0]       out_flag_value,
  output logic [15:0]      out_next_address,
  output logic             out_store_enable,
  output logic [15:0]      out_store_address,
  output logic [7:0]       out_store_data,
  output logic [1:0]       out_status
);

  // input register
  logic        in_valid_r;
  logic [7:0]  op_r;
  logic [15:0] word_r;
  logic [7:0]  mem_r;

  // architectural state
  logic [7:0]       regs_r [ebce_pkg::NUM_GPR];
  logic [7:0]       regs_nxt [ebce_pkg::NUM_GPR];
  logic [7:0]       acc_r, acc_nxt;
  ebce_pkg::flags_t flags_r, flags_nxt;
  logic [15:0]      pc_r, pc_nxt;

  // result register
  logic              out_valid_r;
  logic [7:0]        res_acc_r;
  logic [3:0]        res_flags_r;
  logic [15:0]       res_pc_r;
  logic              res_st_r;
  logic [15:0]       res_addr_r;
  logic [7:0]        res_data_r;
  ebce_pkg::status_t res_status_r;

  // execute-stage signals
  logic                exec_go;
  logic [7:0]          d8;
  logic [2:0]          dst;
  logic [7:0]          src_val;
  logic [15:0]         hl;
  logic [15:0]         jr_target;
  logic                take;
  logic                st;
  logic [7:0]          sdata;
  ebce_pkg::status_t   status;
  logic                is_cp_d8;
  logic [7:0]          alu_b;
  ebce_pkg::alu_op_t   alu_op;
  ebce_pkg::alu_res_t  alu_res;

  // handshake
  assign exec_go  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || exec_go;

  // operand fields
  assign d8        = word_r[7:0];
  assign dst       = op_r[5:3];
  assign hl        = {regs_r[ebce_pkg::REG_H], regs_r[ebce_pkg::REG_L]};
  assign jr_target = pc_r + 16'd2 + {{8{d8[7]}}, d8};

  // source operand select
  always_comb begin
    if (op_r[2:0] == ebce_pkg::REG_MEM) begin
      src_val = mem_r;
    end else if (op_r[2:0] == ebce_pkg::REG_A) begin
      src_val = acc_r;
    end else begin
      src_val = regs_r[op_r[2:0]];
    end
  end

  // ALU
  assign is_cp_d8 = (op_r == ebce_pkg::OP_CP_D8);
  assign alu_b    = is_cp_d8 ? d8 : src_val;
  assign alu_op   = is_cp_d8 ? ebce_pkg::ALU_CP : ebce_pkg::alu_op_t'(op_r[5:3]);

  ebce_alu u_alu (
    .acc      (acc_r),
    .operand  (alu_b),
    .carry_in (flags_r.c),
    .op       (alu_op),
    .res      (alu_res)
  );

  // branch condition
  always_comb begin
    case (op_r)
      ebce_pkg::OP_JR_NZ: take = !flags_r.z;
      ebce_pkg::OP_JR_Z:  take = flags_r.z;
      ebce_pkg::OP_JR_NC: take = !flags_r.c;
      ebce_pkg::OP_JR_C:  take = flags_r.c;
      default:            take = 1'b1;
    endcase
  end

  // decode and next state
  always_comb begin
    regs_nxt  = regs_r;
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    pc_nxt    = pc_r;
    st        = 1'b0;
    sdata     = 8'd0;
    status    = ebce_pkg::ST_OK;
    case (op_r) inside
      ebce_pkg::OP_NOP: begin
        pc_nxt = pc_r + 16'd1;
      end
      8'b00???110: begin
        // load immediate
        if (dst == ebce_pkg::REG_MEM) begin
          st    = 1'b1;
          sdata = d8;
        end else if (dst == ebce_pkg::REG_A) begin
          acc_nxt = d8;
        end else begin
          regs_nxt[dst] = d8;
        end
        pc_nxt = pc_r + 16'd2;
      end
      ebce_pkg::OP_JR, ebce_pkg::OP_JR_NZ, ebce_pkg::OP_JR_Z,
      ebce_pkg::OP_JR_NC, ebce_pkg::OP_JR_C: begin
        pc_nxt = take ? jr_target : (pc_r + 16'd2);
      end
      ebce_pkg::OP_HALT: begin
        status = ebce_pkg::ST_HALT;
        pc_nxt = pc_r + 16'd1;
      end
      [8'h40:8'h7F]: begin
        // register to register load
        if (dst == ebce_pkg::REG_MEM) begin
          st    = 1'b1;
          sdata = src_val;
        end else if (dst == ebce_pkg::REG_A) begin
          acc_nxt = src_val;
        end else begin
          regs_nxt[dst] = src_val;
        end
        pc_nxt = pc_r + 16'd1;
      end
      [8'h80:8'hBF]: begin
        acc_nxt   = alu_res.acc;
        flags_nxt = alu_res.flags;
        pc_nxt    = pc_r + 16'd1;
      end
      ebce_pkg::OP_JP: begin
        pc_nxt = word_r;
      end
      ebce_pkg::OP_CP_D8: begin
        flags_nxt = alu_res.flags;
        pc_nxt    = pc_r + 16'd2;
      end
      default: begin
        status = ebce_pkg::ST_UNSUP;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      regs_r      <= '{default: 8'd0};
      acc_r       <= 8'd0;
      flags_r     <= '0;
      pc_r        <= 16'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
        regs_r      <= regs_nxt;
        acc_r       <= acc_nxt;
        flags_r     <= flags_nxt;
        pc_r        <= pc_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r   <= in_opcode;
      word_r <= in_operand_word;
      mem_r  <= in_hl_byte;
    end
    if (exec_go) begin
      res_acc_r    <= acc_nxt;
      res_flags_r  <= flags_nxt;
      res_pc_r     <= pc_nxt;
      res_st_r     <= st;
      res_addr_r   <= st ? hl : 16'd0;
      res_data_r   <= sdata;
      res_status_r <= status;
    end
  end

  // outputs
  assign out_valid         = out_valid_r;
  assign out_acc_value     = res_acc_r;
  assign out_flag_value    = {res_flags_r, 4'b0000};
  assign out_next_address  = res_pc_r;
  assign out_store_enable  = res_st_r;
  assign out_store_address = res_addr_r;
  assign out_store_data    = res_data_r;
  assign out_status        = res_status_r;

endmodule

`default_nettype wire

FILE: dv/eight_bit_cpu_execute_step_tb.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_step_tb - self-checking bench for the CPU execute step
// Feeds fetched instructions through a valid/ready driver and mirrors the
// architectural state (B..L, A, F, PC) in a local instruction-level predictor.
// Every retired instruction is checked field by field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eight_bit_cpu_execute_step_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RANDOM_ITEMS = 400;   // per random phase
  localparam int unsigned DRAIN_CYCLES = 20;

  // opcode groups, bits 7..6
  localparam logic [1:0] GRP_MISC = 2'b00;
  localparam logic [1:0] GRP_LD   = 2'b01;
  localparam logic [1:0] GRP_ALU  = 2'b10;

  // opcodes the block must reject
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_LDH_IO  = 8'hE0;
  localparam logic [7:0] OP_LD_A16  = 8'hEA;
  localparam logic [7:0] OP_DI      = 8'hF3;
  localparam logic [7:0] OP_EI      = 8'hFB;
  localparam logic [7:0] OP_RST_38  = 8'hFF;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] word;
    logic [7:0]  hl_byte;
  } instr_t;

  typedef struct packed {
    logic [7:0]        acc;
    logic [7:0]        flag;
    logic [15:0]       pc;
    logic              st_en;
    logic [15:0]       st_addr;
    logic [7:0]        st_data;
    ebce_pkg::status_t status;
  } retire_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_opcode = '0;
  logic [15:0] in_operand_word = '0;
  logic [7:0]  in_hl_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_acc_value;
  logic [7:0]  out_flag_value;
  logic [15:0] out_next_address;
  logic        out_store_enable;
  logic [15:0] out_store_address;
  logic [7:0]  out_store_data;
  logic [1:0]  out_status;

  eight_bit_cpu_execute_step u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_operand_word   (in_operand_word),
    .in_hl_byte        (in_hl_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_acc_value     (out_acc_value),
    .out_flag_value    (out_flag_value),
    .out_next_address  (out_next_address),
    .out_store_enable  (out_store_enable),
    .out_store_address (out_store_address),
    .out_store_data    (out_store_data),
    .out_status        (out_status)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Bench state
  instr_t      fetch_q[$];        // instructions waiting to be driven
  retire_t     retire_q[$];       // predicted retirements, oldest first
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          in_took = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;

  // Mirrored architectural state
  logic [7:0]       cpu_gpr [ebce_pkg::NUM_GPR];
  logic [7:0]       cpu_a;
  ebce_pkg::flags_t cpu_f;
  logic [15:0]      cpu_pc;

  function automatic logic [7:0] operand_of(logic [2:0] sel, logic [7:0] mem);
    if (sel == ebce_pkg::REG_MEM) return mem;
    if (sel == ebce_pkg::REG_A) return cpu_a;
    return cpu_gpr[sel];
  endfunction

  function automatic void load_reg(logic [2:0] sel, logic [7:0] v);
    if (sel == ebce_pkg::REG_A) cpu_a = v;
    else if (sel != ebce_pkg::REG_MEM) cpu_gpr[sel] = v;
  endfunction

  // 8-bit ALU; carry-in for ADC/SBC is the carry held before the op
  function automatic void alu_exec(ebce_pkg::alu_op_t op, logic [7:0] b);
    logic [8:0]       sum;
    logic [4:0]       nib;
    logic             cy;
    logic [7:0]       r;
    ebce_pkg::flags_t f;
    f  = '0;
    cy = 1'b0;
    case (op)
      ebce_pkg::ALU_ADD, ebce_pkg::ALU_ADC: begin
        if (op == ebce_pkg::ALU_ADC) cy = cpu_f.c;
        sum   = {1'b0, cpu_a} + {1'b0, b} + {8'd0, cy};
        nib   = {1'b0, cpu_a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
        f.h   = nib[4];
        f.c   = sum[8];
        r     = sum[7:0];
        cpu_a = r;
      end
      ebce_pkg::ALU_SUB, ebce_pkg::ALU_SBC, ebce_pkg::ALU_CP: begin
        if (op == ebce_pkg::ALU_SBC) cy = cpu_f.c;
        // borrow shows up as the sign bit of the widened difference
        sum = {1'b0, cpu_a} - {1'b0, b} - {8'd0, cy};
        nib = {1'b0, cpu_a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
        f.n = 1'b1;
        f.h = nib[4];
        f.c = sum[8];
        r   = sum[7:0];
        if (op != ebce_pkg::ALU_CP) cpu_a = r;
      end
      ebce_pkg::ALU_AND: begin
        r     = cpu_a & b;
        f.h   = 1'b1;
        cpu_a = r;
      end
      ebce_pkg::ALU_XOR: begin
        r     = cpu_a ^ b;
        cpu_a = r;
      end
      default: begin
        r     = cpu_a | b;
        cpu_a = r;
      end
    endcase
    f.z   = (r == 8'h00);
    cpu_f = f;
  endfunction

  // Retire one instruction against the mirrored state
  function automatic retire_t execute_instr(instr_t it);
    retire_t     res;
    logic [7:0]  d8;
    logic [15:0] hl;
    logic [15:0] pc;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [7:0]  v;
    logic        take;
    res        = '0;
    res.status = ebce_pkg::ST_OK;
    d8         = it.word[7:0];
    hl         = {cpu_gpr[ebce_pkg::REG_H], cpu_gpr[ebce_pkg::REG_L]};
    pc         = cpu_pc;
    dst        = it.opcode[5:3];
    src        = it.opcode[2:0];
    take       = 1'b0;
    if (it.opcode == ebce_pkg::OP_NOP) begin
      pc = pc + 16'd1;
    end else if (it.opcode[7:6] == GRP_MISC && src == ebce_pkg::REG_MEM) begin
      // LD r,d8 and LD (HL),d8
      if (dst == ebce_pkg::REG_MEM) begin
        res.st_en   = 1'b1;
        res.st_data = d8;
      end else begin
        load_reg(dst, d8);
      end
      pc = pc + 16'd2;
    end else if (it.opcode == ebce_pkg::OP_JR || it.opcode == ebce_pkg::OP_JR_NZ ||
                 it.opcode == ebce_pkg::OP_JR_Z || it.opcode == ebce_pkg::OP_JR_NC ||
                 it.opcode == ebce_pkg::OP_JR_C) begin
      case (it.opcode)
        ebce_pkg::OP_JR:    take = 1'b1;
        ebce_pkg::OP_JR_NZ: take = !cpu_f.z;
        ebce_pkg::OP_JR_Z:  take = cpu_f.z;
        ebce_pkg::OP_JR_NC: take = !cpu_f.c;
        default:            take = cpu_f.c;
      endcase
      pc = pc + 16'd2;
      if (take) pc = pc + {{8{d8[7]}}, d8};
    end else if (it.opcode == ebce_pkg::OP_HALT) begin
      res.status = ebce_pkg::ST_HALT;
      pc         = pc + 16'd1;
    end else if (it.opcode[7:6] == GRP_LD) begin
      v = operand_of(src, it.hl_byte);
      if (dst == ebce_pkg::REG_MEM) begin
        res.st_en   = 1'b1;
        res.st_data = v;
      end else begin
        load_reg(dst, v);
      end
      pc = pc + 16'd1;
    end else if (it.opcode[7:6] == GRP_ALU) begin
      alu_exec(ebce_pkg::alu_op_t'(dst), operand_of(src, it.hl_byte));
      pc = pc + 16'd1;
    end else if (it.opcode == ebce_pkg::OP_JP) begin
      pc = it.word;
    end else if (it.opcode == ebce_pkg::OP_CP_D8) begin
      alu_exec(ebce_pkg::ALU_CP, d8);
      pc = pc + 16'd2;
    end else begin
      res.status = ebce_pkg::ST_UNSUP;
    end
    if (res.st_en) res.st_addr = hl;
    cpu_pc   = pc;
    res.acc  = cpu_a;
    res.flag = {cpu_f, 4'b0000};
    res.pc   = cpu_pc;
    return res;
  endfunction

  task automatic queue_instr(logic [7:0] op, logic [15:0] word, logic [7:0] mem);
    instr_t it;
    it.opcode  = op;
    it.word    = word;
    it.hl_byte = mem;
    fetch_q.push_back(it);
    n_queued++;
  endtask

  // Operand word with the low byte biased toward edge values
  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       w[7:0] = 8'h00;
      1:       w[7:0] = 8'hFF;
      2:       w[7:0] = 8'h80;
      3:       w[7:0] = 8'h7F;
      default: ;
    endcase
    return w;
  endfunction

  // Mostly supported instructions, the rest any opcode byte
  function automatic logic [7:0] rand_opcode();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return {GRP_ALU, 6'($urandom)};
    if (pick < 45) return {GRP_MISC, 3'($urandom), ebce_pkg::REG_MEM};
    if (pick < 60) return {GRP_LD, 6'($urandom)};
    if (pick < 70) begin
      case ($urandom_range(0, 4))
        0:       return ebce_pkg::OP_JR;
        1:       return ebce_pkg::OP_JR_NZ;
        2:       return ebce_pkg::OP_JR_Z;
        3:       return ebce_pkg::OP_JR_NC;
        default: return ebce_pkg::OP_JR_C;
      endcase
    end
    if (pick < 75) return ebce_pkg::OP_CP_D8;
    if (pick < 78) return ebce_pkg::OP_JP;
    if (pick < 81) return ebce_pkg::OP_NOP;
    return 8'($urandom);
  endfunction

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      queue_instr(rand_opcode(), rand_word(), 8'($urandom));
  endtask

  // Block until every queued transaction has retired
  task automatic wait_drained();
    while (n_taken < n_queued || retire_q.size() > 0) @(posedge clk);
  endtask

  // Input driver: changes on the falling edge
  always @(negedge clk) begin
    instr_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (fetch_q.size() > 0) begin
        it = fetch_q.pop_front();
        in_opcode       <= it.opcode;
        in_operand_word <= it.word;
        in_hl_byte      <= it.hl_byte;
        in_valid        <= 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result backpressure in random bursts
  always @(negedge clk) begin
    if (!gaps_on) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check retirements, then predict newly accepted instructions
  always @(posedge clk) begin
    retire_t got;
    retire_t want;
    instr_t  it;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      got.acc     = out_acc_value;
      got.flag    = out_flag_value;
      got.pc      = out_next_address;
      got.st_en   = out_store_enable;
      got.st_addr = out_store_address;
      got.st_data = out_store_data;
      got.status  = ebce_pkg::status_t'(out_status);
      if (retire_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: unexpected retirement acc=%h f=%h pc=%h st=%b/%h/%h status=%0d",
                   got.acc, got.flag, got.pc, got.st_en, got.st_addr, got.st_data,
                   got.status);
      end else begin
        want = retire_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("ERROR: retirement mismatch at cycle %0d", n_cycles);
            $display("  expected acc=%h f=%h pc=%h st=%b/%h/%h status=%0d",
                     want.acc, want.flag, want.pc, want.st_en, want.st_addr,
                     want.st_data, want.status);
            $display("  actual   acc=%h f=%h pc=%h st=%b/%h/%h status=%0d",
                     got.acc, got.flag, got.pc, got.st_en, got.st_addr,
                     got.st_data, got.status);
          end
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      it.opcode  = in_opcode;
      it.word    = in_operand_word;
      it.hl_byte = in_hl_byte;
      retire_q.push_back(execute_instr(it));
      n_taken++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sequence
  initial begin
    for (int i = 0; i < ebce_pkg::NUM_GPR; i++) cpu_gpr[i] = 8'h00;
    cpu_a  = 8'h00;
    cpu_f  = '0;
    cpu_pc = 16'h0000;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: loads, store to (HL), every ALU op, jumps, halt, rejects
    queue_instr({GRP_MISC, 3'd0, ebce_pkg::REG_MEM}, 16'h12FF, 8'h00);         // LD B,FF
    queue_instr({GRP_MISC, ebce_pkg::REG_H, ebce_pkg::REG_MEM}, 16'h0080, 8'h00); // LD H,80
    queue_instr({GRP_MISC, ebce_pkg::REG_L, ebce_pkg::REG_MEM}, 16'hFF01, 8'h00); // LD L,01
    queue_instr({GRP_MISC, ebce_pkg::REG_A, ebce_pkg::REG_MEM}, 16'h000F, 8'h00); // LD A,0F
    queue_instr({GRP_MISC, ebce_pkg::REG_MEM, ebce_pkg::REG_MEM}, 16'hFFA5,
                8'h3C);                                                         // LD (HL),A5
    queue_instr({GRP_LD, 3'd1, ebce_pkg::REG_MEM}, 16'h0000, 8'hFF);           // LD C,(HL)
    queue_instr({GRP_LD, ebce_pkg::REG_MEM, ebce_pkg::REG_A}, 16'hFFFF, 8'h00); // LD (HL),A
    queue_instr({GRP_ALU, ebce_pkg::ALU_ADD, ebce_pkg::REG_A}, 16'h0000, 8'h00); // half carry
    queue_instr({GRP_ALU, ebce_pkg::ALU_ADD, 3'd0}, 16'h0000, 8'h00);          // full carry
    queue_instr({GRP_ALU, ebce_pkg::ALU_ADC, ebce_pkg::REG_MEM}, 16'h0000, 8'hFF); // carry in
    queue_instr({GRP_ALU, ebce_pkg::ALU_SUB, ebce_pkg::REG_MEM}, 16'h0000, 8'h01);
    queue_instr({GRP_ALU, ebce_pkg::ALU_SBC, 3'd0}, 16'h0000, 8'h00);          // borrow out
    queue_instr({GRP_ALU, ebce_pkg::ALU_SBC, ebce_pkg::REG_MEM}, 16'h0000, 8'hFF); // borrow in
    queue_instr({GRP_ALU, ebce_pkg::ALU_AND, 3'd1}, 16'h0000, 8'h00);
    queue_instr({GRP_ALU, ebce_pkg::ALU_XOR, ebce_pkg::REG_A}, 16'h0000, 8'h00); // zero result
    queue_instr({GRP_ALU, ebce_pkg::ALU_OR, ebce_pkg::REG_MEM}, 16'h0000, 8'h00);
    queue_instr(ebce_pkg::OP_CP_D8, 16'h0000, 8'h00);
    queue_instr({GRP_ALU, ebce_pkg::ALU_CP, 3'd0}, 16'h0000, 8'h00);
    queue_instr(ebce_pkg::OP_JR_Z, 16'h0080, 8'h00);                  // not taken
    queue_instr(ebce_pkg::OP_JR_C, 16'h007F, 8'h00);                  // taken after borrow
    queue_instr(ebce_pkg::OP_JR_NZ, 16'h0010, 8'h00);
    queue_instr(ebce_pkg::OP_JR_NC, 16'h0010, 8'h00);                 // not taken
    queue_instr(ebce_pkg::OP_JP, 16'hFFFF, 8'h00);
    queue_instr(ebce_pkg::OP_NOP, 16'h0000, 8'h00);                   // PC wraps to zero
    queue_instr(ebce_pkg::OP_JR, 16'h00FE, 8'h00);
    queue_instr(ebce_pkg::OP_HALT, 16'h0000, 8'h00);
    queue_instr(OP_CALL, 16'h1234, 8'h00);
    queue_instr(OP_LDH_IO, 16'h00FF, 8'h00);
    queue_instr(OP_LD_A16, 16'hC000, 8'h00);
    queue_instr(OP_DI, 16'h0000, 8'h00);
    queue_instr(OP_EI, 16'h0000, 8'h00);
    queue_instr(OP_RST_38, 16'hFFFF, 8'hFF);
    wait_drained();

    // Random with idling on both sides
    queue_random(RANDOM_ITEMS);
    wait_drained();

    // Last stretch at full rate
    gaps_on = 1'b0;
    queue_random(RANDOM_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: eight_bit_cpu_execute_step.f
design/ebce_pkg.sv
design/ebce_alu.sv
design/eight_bit_cpu_execute_step.sv
dv/eight_bit_cpu_execute_step_tb.sv
